// ===== rtl/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, sizes and helpers of the binary cross entropy loss block.
// ----------------------------------------------------------------------------
package bce_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int LOG_TABLE_BITS = 10;

   localparam int DATA_W  = 16;
   localparam int LOSS_W  = 20;
   localparam int LAST_W  = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam int DIM_W   = LAST_W + 1;
   localparam int DIV_W   = 2 * DIM_W;
   localparam int TOTAL_W = 56;
   localparam int DVD_W   = TOTAL_W + 1;
   localparam int CNT_W   = $clog2(DVD_W);
   localparam int NL2_W   = LOG_TABLE_BITS + 5;
   localparam int PLN_W   = NL2_W + 32;
   localparam int LN_W    = 20;
   localparam int TA_W    = DATA_W + LN_W;
   localparam int TB_W    = DATA_W + 1 + LN_W;
   localparam int ITER_W  = $clog2(LOG_TABLE_BITS + 1);
   localparam int QDEPTH  = 2;

   localparam logic [31:0]     LN2_Q32  = 32'd2977044472;
   localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] prediction;
      logic [DATA_W-1:0] target;
      logic              last;
   } bce_item_type;

   typedef struct packed {
      logic [15:0] row_count;
      logic [15:0] col_count;
   } bce_cfg_type;

   typedef struct packed {
      logic valid;
      logic full;
   } bce_qstat_type;

   typedef struct packed {
      logic idle;
      logic out_state;
   } bce_bstat_type;

   // Last index of a dimension; a count of zero wraps to the full range.
   function automatic logic [LAST_W-1:0] last_index(input logic [15:0] count);
      logic [15:0] dec;
      dec = count - 16'd1;
      return dec[LAST_W-1:0];
   endfunction

endpackage

// ===== rtl/binary_cross_entropy_loss.sv =====
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss
// Mean binary cross entropy over a streamed prediction and target matrix.
// ----------------------------------------------------------------------------
// Each word carries one prediction and one target in Q0.16, in row-major
// order. In the back end a word runs two logarithms (each a setup, ten
// squaring steps, a multiply and a rounding step), then two products and
// the accumulate; the squaring steps of both share one squaring multiplier.
// The last word of a matrix then runs a bit-serial divide of the 56-bit
// total by rows times columns, after which one result word gives the mean in
// Q4.16 and a flag for any zero prediction. A two-word queue lets the input
// keep accepting until full while the back end works or a result waits.
module binary_cross_entropy_loss (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bce_pkg::DATA_W-1:0]  req_prediction,
   input  logic [bce_pkg::DATA_W-1:0]  req_target,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bce_pkg::LOSS_W-1:0]  rsp_loss,
   output logic                        rsp_clamped,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import bce_pkg::*;

   logic [15:0]   row_count_ff, col_count_ff;
   bce_cfg_type   cfg;
   bce_qstat_type q_stat;
   bce_bstat_type b_stat;
   bce_item_type  push_item, pop_item;
   logic          push, pop;
   logic          wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg.row_count = row_count_ff;
   assign cfg.col_count = col_count_ff;
   assign prdata = (paddr[2] == REG_COL_COUNT) ? {16'b0, col_count_ff} : {16'b0, row_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 16'd1;
         col_count_ff <= 16'd1;
      end else if (wr_en) begin
         if (paddr[2] == REG_ROW_COUNT) begin
            row_count_ff <= pwdata[15:0];
         end else begin
            col_count_ff <= pwdata[15:0];
         end
      end
   end

   bce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_prediction (req_prediction),
      .req_target     (req_target),
      .q_stat         (q_stat),
      .push           (push),
      .push_item      (push_item)
   );

   bce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   bce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_stat      (q_stat),
      .pop_item    (pop_item),
      .pop         (pop),
      .b_stat      (b_stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_loss    (rsp_loss),
      .rsp_clamped (rsp_clamped)
   );

`ifndef SYNTHESIS
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_stat.valid && b_stat.idle))
      else $error("queue popped while empty or back end busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_stat.out_state))
      else $error("result word raised outside the output state");
`endif

endmodule

// ===== rtl/bce_front.sv =====
// ----------------------------------------------------------------------------
// bce_front
// Accepts input words, tracks the row and column position and tags the
// last element of each matrix before handing the word to the queue.
// ----------------------------------------------------------------------------
module bce_front (
   input  logic                        clock,
   input  logic                        reset,
   input  bce_pkg::bce_cfg_type        cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bce_pkg::DATA_W-1:0]  req_prediction,
   input  logic [bce_pkg::DATA_W-1:0]  req_target,
   input  bce_pkg::bce_qstat_type      q_stat,
   output logic                        push,
   output bce_pkg::bce_item_type       push_item
);
   import bce_pkg::*;

   logic [COUNT_BITS-1:0] col_idx_ff, col_idx_in;
   logic [COUNT_BITS-1:0] row_idx_ff, row_idx_in;
   logic [COUNT_BITS-1:0] col_last, row_last;
   logic                  col_end, row_end;

   assign col_last = COUNT_BITS'(last_index(cfg.col_count));
   assign row_last = COUNT_BITS'(last_index(cfg.row_count));
   assign col_end  = (col_idx_ff == col_last);
   assign row_end  = (row_idx_ff == row_last);

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   assign push_item.prediction = req_prediction;
   assign push_item.target     = req_target;
   assign push_item.last       = col_end && row_end;

   always_comb begin
      col_idx_in = col_idx_ff;
      row_idx_in = row_idx_ff;
      if (push) begin
         if (!col_end) begin
            col_idx_in = col_idx_ff + 1'b1;
         end else begin
            col_idx_in = '0;
            row_idx_in = row_end ? '0 : row_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_idx_ff <= '0;
         row_idx_ff <= '0;
      end else begin
         col_idx_ff <= col_idx_in;
         row_idx_ff <= row_idx_in;
      end
   end

endmodule

// ===== rtl/bce_queue.sv =====
// ----------------------------------------------------------------------------
// bce_queue
// Two-entry queue of tagged words between the front and the back.
// ----------------------------------------------------------------------------
module bce_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bce_pkg::bce_item_type  push_item,
   input  logic                   pop,
   output bce_pkg::bce_item_type  pop_item,
   output bce_pkg::bce_qstat_type q_stat
);
   import bce_pkg::*;

   localparam int PTR_W = $clog2(QDEPTH);

   bce_item_type          mem_ff [QDEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]        cnt_ff, cnt_in;

   assign q_stat.valid = (cnt_ff != '0);
   assign q_stat.full  = (cnt_ff == (PTR_W+1)'(QDEPTH));
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/bce_back.sv =====
// ----------------------------------------------------------------------------
// bce_back
// Evaluates both logarithm terms with a shared squaring unit, accumulates
// the loss and divides the total by the element count at the matrix end.
// ----------------------------------------------------------------------------
module bce_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bce_pkg::bce_cfg_type        cfg,
   input  bce_pkg::bce_qstat_type      q_stat,
   input  bce_pkg::bce_item_type       pop_item,
   output logic                        pop,
   output bce_pkg::bce_bstat_type      b_stat,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bce_pkg::LOSS_W-1:0]  rsp_loss,
   output logic                        rsp_clamped
);
   import bce_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_LOGINIT = 11'b000_0000_0010,
      S_SQUARE  = 11'b000_0000_0100,
      S_LNMUL   = 11'b000_0000_1000,
      S_LNRND   = 11'b000_0001_0000,
      S_TERMA   = 11'b000_0010_0000,
      S_TERMB   = 11'b000_0100_0000,
      S_ACC     = 11'b000_1000_0000,
      S_DIVLOAD = 11'b001_0000_0000,
      S_DIV     = 11'b010_0000_0000,
      S_OUT     = 11'b100_0000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_W-1:0]     p_ff, t_ff;
   logic                  last_ff;
   logic                  which_ff;
   logic [31:0]           m_ff;
   logic [LOG_TABLE_BITS-1:0] f_ff;
   logic [ITER_W-1:0]     iter_ff;
   logic [4:0]            e_ff;
   logic [PLN_W-1:0]      prod_ff;
   logic [LN_W-1:0]       lna_ff, lnb_ff;
   logic [TA_W-1:0]       ta_ff;
   logic [TB_W-1:0]       tb_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic                  clamp_ff;
   logic [DIV_W-1:0]      div_ff;
   logic [DVD_W-1:0]      dvd_ff;
   logic [DIV_W-1:0]      rem_ff;
   logic [DVD_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  rsp_valid_ff;
   logic [LOSS_W-1:0]     rsp_loss_ff;
   logic                  rsp_clamped_ff;

   logic [16:0]           x;
   logic [4:0]            e;
   logic [47:0]           m_wide;
   logic [63:0]           sq;
   logic [32:0]           sq_top;
   logic [NL2_W-1:0]      nl2;
   logic [PLN_W-1:0]      ln_sum;
   logic [LN_W-1:0]       ln_val;
   logic [TB_W:0]         term_sum;
   logic [DIV_W:0]        trial;
   logic                  trial_ge;
   logic                  out_load;

   assign pop    = (state_ff == S_IDLE) && q_stat.valid;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign b_stat.idle      = (state_ff == S_IDLE);
   assign b_stat.out_state = (state_ff == S_OUT);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_loss    = rsp_loss_ff;
   assign rsp_clamped = rsp_clamped_ff;

   // Logarithm argument; a zero prediction is clamped to one LSB.
   always_comb begin
      if (which_ff) begin
         x = 17'h10000 - {1'b0, p_ff};
      end else begin
         x = (p_ff == '0) ? 17'd1 : {1'b0, p_ff};
      end
      e = '0;
      for (int i = 1; i < 17; i++) begin
         if (x[i]) begin
            e = 5'(i);
         end
      end
   end

   assign m_wide  = {31'b0, x} << (5'd31 - e);
   assign sq      = {32'b0, m_ff} * {32'b0, m_ff};
   assign sq_top  = sq[63:31];
   assign nl2     = (NL2_W'(5'd16 - e_ff) << LOG_TABLE_BITS) - NL2_W'(f_ff);
   assign ln_sum  = prod_ff + (PLN_W'(1) << (LOG_TABLE_BITS + 15));
   assign ln_val  = LN_W'(ln_sum >> (LOG_TABLE_BITS + 16));
   assign term_sum = (TB_W+1)'(ta_ff) + (TB_W+1)'(tb_ff) + (TB_W+1)'(32768);
   assign trial    = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (q_stat.valid) state_in = S_LOGINIT;
         S_LOGINIT: state_in = S_SQUARE;
         S_SQUARE:  if (iter_ff == ITER_W'(LOG_TABLE_BITS - 1)) state_in = S_LNMUL;
         S_LNMUL:   state_in = S_LNRND;
         S_LNRND:   state_in = which_ff ? S_TERMA : S_LOGINIT;
         S_TERMA:   state_in = S_TERMB;
         S_TERMB:   state_in = S_ACC;
         S_ACC:     state_in = last_ff ? S_DIVLOAD : S_IDLE;
         S_DIVLOAD: state_in = S_DIV;
         S_DIV:     if (cnt_ff == '0) state_in = S_OUT;
         S_OUT:     if (out_load) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         clamp_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_LOGINIT && !which_ff && p_ff == '0) begin
            clamp_ff <= 1'b1;
         end
         if (state_ff == S_ACC) begin
            total_ff <= total_ff + TOTAL_W'(term_sum >> 16);
         end
         if (out_load) begin
            total_ff     <= '0;
            clamp_ff     <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            p_ff     <= pop_item.prediction;
            t_ff     <= pop_item.target;
            last_ff  <= pop_item.last;
            which_ff <= 1'b0;
         end
         S_LOGINIT: begin
            m_ff    <= m_wide[31:0];
            e_ff    <= e;
            f_ff    <= '0;
            iter_ff <= '0;
         end
         S_SQUARE: begin
            // A square at or above two yields a one bit and is halved.
            if (sq_top[32]) begin
               m_ff <= sq_top[32:1];
               f_ff <= {f_ff[LOG_TABLE_BITS-2:0], 1'b1};
            end else begin
               m_ff <= sq_top[31:0];
               f_ff <= {f_ff[LOG_TABLE_BITS-2:0], 1'b0};
            end
            iter_ff <= iter_ff + 1'b1;
         end
         S_LNMUL: begin
            prod_ff <= PLN_W'(nl2) * PLN_W'(LN2_Q32);
         end
         S_LNRND: begin
            if (which_ff) begin
               lnb_ff <= ln_val;
            end else begin
               lna_ff <= ln_val;
            end
            which_ff <= 1'b1;
         end
         S_TERMA: begin
            ta_ff <= TA_W'(t_ff) * TA_W'(lna_ff);
         end
         S_TERMB: begin
            tb_ff <= TB_W'(17'h10000 - {1'b0, t_ff}) * TB_W'(lnb_ff);
         end
         S_ACC: begin
            div_ff <= DIV_W'(DIM_W'(last_index(cfg.row_count)) + 1'b1)
                    * DIV_W'(DIM_W'(last_index(cfg.col_count)) + 1'b1);
         end
         S_DIVLOAD: begin
            dvd_ff <= DVD_W'(total_ff) + DVD_W'(div_ff >> 1);
            rem_ff <= '0;
            cnt_ff <= CNT_W'(DVD_W - 1);
         end
         S_DIV: begin
            rem_ff <= trial_ge ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);
            quo_ff <= {quo_ff[DVD_W-2:0], trial_ge};
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_loss_ff    <= (quo_ff > DVD_W'(LOSS_MAX)) ? LOSS_MAX : quo_ff[LOSS_W-1:0];
               rsp_clamped_ff <= clamp_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
